>>> hw/rtl/ibs_pkg.sv
package ibs_pkg;

    // Item codes carried on the opcode port.
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_MERGE   = 1'b1;

    // Sequencer states of the bounding sphere unit.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_SQUARE,
        S_ROOT_START,
        S_ROOT_WAIT,
        S_DECIDE,
        S_MUL,
        S_DIV_LOAD,
        S_DIV,
        S_MOVE,
        S_DONE
    } ibs_state_t;

endpackage

>>> hw/rtl/incremental_bounding_sphere_unit.sv
// Incremental bounding sphere unit. Each item on the input channel is either a
// restart (opcode 0), which loads the incoming sphere, or a merge (opcode 1),
// which grows the kept sphere to enclose the incoming one; every item yields
// one result item carrying the sphere after the update. Coordinates are signed
// fixed point, the radius unsigned with one bit less, and the radius
// saturates. A restart loads the kept sphere in the delta state and goes
// straight to the final state. A merge takes the bit-serial square root of the
// squared distance; then, unless the incoming sphere encloses the kept one or
// the distance is zero, the per-axis offset runs through one shared multiplier
// and one restoring divider of COORD_WIDTH+1 steps, with a multiply, a divider
// load and an update step around it, once for each of the three axes. The
// remaining states take the item, form the deltas, sum the three squares,
// start the root, decide the case and load the result. The unit takes one item
// at a time; a finished result waits in the output register while the next
// item is taken, and a result that is still waiting there holds the unit in
// its final state until the receiver takes it.
module incremental_bounding_sphere_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    input  logic [COORD_WIDTH-2:0]        in_radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic [COORD_WIDTH-2:0]        out_radius
);

    localparam int W   = COORD_WIDTH;
    localparam int RB  = W + 2;              // root width
    localparam int GW  = W + 3;              // growth width
    localparam int PW  = (W + 1) + GW;       // product width
    localparam int QCW = $clog2(W + 1);

    localparam logic signed [W+1:0] CMAX = (W+2)'((longint'(1) <<< (W - 1)) - longint'(1));
    localparam logic signed [W+1:0] CMIN = -CMAX - (W+2)'(1);

    ibs_pkg::ibs_state_t state_reg, state_next;

    logic                   op_reg;
    logic signed [W-1:0]    ix_reg, iy_reg, iz_reg;
    logic [W-2:0]           ir_reg;
    logic signed [W-1:0]    cx_reg, cy_reg, cz_reg;
    logic [W-2:0]           rad_reg;
    logic signed [W:0]      dx_reg, dy_reg, dz_reg;
    logic [1:0]             cnt_reg;
    logic [2*RB-1:0]        acc_reg;
    logic [PW-1:0]          prod_reg;
    logic [RB-1:0]          d_reg;
    logic [GW-1:0]          g_reg;
    logic [1:0]             axis_reg;
    logic [W+2:0]           rem_reg;
    logic [QCW-1:0]         bit_reg;
    logic [W:0]             q_reg;
    logic                   out_valid_reg;
    logic signed [W-1:0]    ox_reg, oy_reg, oz_reg;
    logic [W-2:0]           orad_reg;

    logic                   root_start;
    logic                   root_done;
    logic [RB-1:0]          root;
    logic                   out_load;

    logic [W:0]             mul_a;
    logic [GW-1:0]          mul_b;
    logic signed [W:0]      d_sel;
    logic signed [W-1:0]    c_sel;
    logic [W:0]             mag_sel;
    logic [W+3:0]           den;
    logic [W:0]             prod_lo;
    logic [W+3:0]           div_t;
    logic                   div_take;
    logic [GW-1:0]          m_sum;
    logic [GW-1:0]          m_max;
    logic [GW-1:0]          g_val;
    logic [GW-1:0]          nr_val;
    logic                   enclose;
    logic signed [W+1:0]    off_s;
    logic signed [W+1:0]    moved;
    logic signed [W-1:0]    moved_c;

    ibs_isqrt #(
        .ROOT_BITS (RB)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (root)
    );

    // Axis selection for the shared multiplier and the divider.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    begin d_sel = dx_reg; c_sel = cx_reg; end
            2'd1:    begin d_sel = dy_reg; c_sel = cy_reg; end
            default: begin d_sel = dz_reg; c_sel = cz_reg; end
        endcase
        mag_sel = d_sel[W] ? (W+1)'(-d_sel) : d_sel;
    end

    // Shared multiplier operands: squares first, then |delta| times growth.
    always_comb
    begin
        if (state_reg == ibs_pkg::S_SQUARE)
        begin
            unique case (cnt_reg)
                2'd0:    mul_a = dx_reg[W] ? (W+1)'(-dx_reg) : dx_reg;
                2'd1:    mul_a = dy_reg[W] ? (W+1)'(-dy_reg) : dy_reg;
                default: mul_a = dz_reg[W] ? (W+1)'(-dz_reg) : dz_reg;
            endcase
            mul_b = GW'(mul_a);
        end
        else
        begin
            mul_a = mag_sel;
            mul_b = g_reg;
        end
    end

    // Growth decision and new radius.
    always_comb
    begin
        m_sum   = GW'(ir_reg) + GW'(d_reg);
        m_max   = (m_sum < GW'(rad_reg)) ? GW'(rad_reg) : m_sum;
        g_val   = m_max - GW'(rad_reg);
        nr_val  = GW'(rad_reg) + (g_val >> 1);
        enclose = (ir_reg > rad_reg) && (GW'(d_reg) < GW'(ir_reg - rad_reg));
    end

    // Restoring divide step and the clamped center update.
    always_comb
    begin
        den      = {1'b0, d_reg, 1'b0};
        prod_lo  = prod_reg[W:0];
        div_t    = {rem_reg, prod_lo[bit_reg]};
        div_take = (div_t >= den);
        off_s    = d_sel[W] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        moved    = (W+2)'(c_sel) + off_s;
        if (moved > CMAX)
            moved_c = CMAX[W-1:0];
        else if (moved < CMIN)
            moved_c = CMIN[W-1:0];
        else
            moved_c = moved[W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ibs_pkg::S_IDLE:
                if (in_valid)
                    state_next = ibs_pkg::S_DELTA;
            ibs_pkg::S_DELTA:
                state_next = (op_reg == ibs_pkg::OP_RESTART) ? ibs_pkg::S_DONE
                                                             : ibs_pkg::S_SQUARE;
            ibs_pkg::S_SQUARE:
                if (cnt_reg == 2'd3)
                    state_next = ibs_pkg::S_ROOT_START;
            ibs_pkg::S_ROOT_START:
                state_next = ibs_pkg::S_ROOT_WAIT;
            ibs_pkg::S_ROOT_WAIT:
                if (root_done)
                    state_next = ibs_pkg::S_DECIDE;
            ibs_pkg::S_DECIDE:
                state_next = (enclose || d_reg == '0) ? ibs_pkg::S_DONE
                                                      : ibs_pkg::S_MUL;
            ibs_pkg::S_MUL:
                state_next = ibs_pkg::S_DIV_LOAD;
            ibs_pkg::S_DIV_LOAD:
                state_next = ibs_pkg::S_DIV;
            ibs_pkg::S_DIV:
                if (bit_reg == '0)
                    state_next = ibs_pkg::S_MOVE;
            ibs_pkg::S_MOVE:
                state_next = (axis_reg == 2'd2) ? ibs_pkg::S_DONE : ibs_pkg::S_MUL;
            ibs_pkg::S_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = ibs_pkg::S_IDLE;
            default:
                state_next = ibs_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready   = (state_reg == ibs_pkg::S_IDLE);
        root_start = (state_reg == ibs_pkg::S_ROOT_START);
        out_load   = (state_reg == ibs_pkg::S_DONE) && (!out_valid_reg || out_ready);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            rad_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // Kept sphere updates.
            if (state_reg == ibs_pkg::S_DELTA && op_reg == ibs_pkg::OP_RESTART)
            begin
                cx_reg  <= ix_reg;
                cy_reg  <= iy_reg;
                cz_reg  <= iz_reg;
                rad_reg <= ir_reg;
            end
            else if (state_reg == ibs_pkg::S_DECIDE)
            begin
                if (enclose)
                begin
                    cx_reg  <= ix_reg;
                    cy_reg  <= iy_reg;
                    cz_reg  <= iz_reg;
                    rad_reg <= ir_reg;
                end
                else if (d_reg != '0)
                begin
                    rad_reg <= (nr_val > GW'({(W-1){1'b1}})) ? {(W-1){1'b1}}
                                                              : nr_val[W-2:0];
                end
            end
            else if (state_reg == ibs_pkg::S_MOVE)
            begin
                unique case (axis_reg)
                    2'd0:    cx_reg <= moved_c;
                    2'd1:    cy_reg <= moved_c;
                    default: cz_reg <= moved_c;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ibs_pkg::S_IDLE:
                if (in_valid)
                begin
                    op_reg <= opcode;
                    ix_reg <= in_x;
                    iy_reg <= in_y;
                    iz_reg <= in_z;
                    ir_reg <= in_radius;
                end
            ibs_pkg::S_DELTA:
            begin
                dx_reg  <= (W+1)'(ix_reg) - (W+1)'(cx_reg);
                dy_reg  <= (W+1)'(iy_reg) - (W+1)'(cy_reg);
                dz_reg  <= (W+1)'(iz_reg) - (W+1)'(cz_reg);
                acc_reg <= '0;
                cnt_reg <= 2'd0;
            end
            ibs_pkg::S_SQUARE:
            begin
                prod_reg <= PW'(mul_a) * PW'(mul_b);
                if (cnt_reg != 2'd0)
                    acc_reg <= acc_reg + (2*RB)'(prod_reg);
                cnt_reg <= cnt_reg + 1'b1;
            end
            ibs_pkg::S_ROOT_WAIT:
                if (root_done)
                    d_reg <= root;
            ibs_pkg::S_DECIDE:
            begin
                g_reg    <= g_val;
                axis_reg <= 2'd0;
            end
            ibs_pkg::S_MUL:
                prod_reg <= PW'(mul_a) * PW'(mul_b);
            ibs_pkg::S_DIV_LOAD:
            begin
                rem_reg <= (W+3)'(prod_reg >> (W + 1));
                bit_reg <= QCW'(W);
                q_reg   <= '0;
            end
            ibs_pkg::S_DIV:
            begin
                rem_reg <= div_take ? (W+3)'(div_t - den) : div_t[W+2:0];
                q_reg   <= {q_reg[W-1:0], div_take};
                bit_reg <= bit_reg - 1'b1;
            end
            ibs_pkg::S_MOVE:
                axis_reg <= axis_reg + 1'b1;
            ibs_pkg::S_DONE:
                if (out_load)
                begin
                    ox_reg   <= cx_reg;
                    oy_reg   <= cy_reg;
                    oz_reg   <= cz_reg;
                    orad_reg <= rad_reg;
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_z      = oz_reg;
    assign out_radius = orad_reg;

`ifndef NO_ASSERTIONS
    // The root unit reports only while the sequencer waits for it.
    a_root_wait: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == ibs_pkg::S_ROOT_WAIT)
        else $error("root finished outside its wait state");

    // The divider remainder stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ibs_pkg::S_DIV |-> {1'b0, rem_reg} < den)
        else $error("divider remainder out of range");

    // An accepted item blocks further input until its result is loaded.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // The axis walk never goes past the third axis.
    a_axis: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ibs_pkg::S_MOVE |-> axis_reg != 2'd3)
        else $error("axis index out of range");
`endif

endmodule

>>> hw/rtl/ibs_isqrt.sv
module ibs_isqrt #(
    parameter int ROOT_BITS = 34
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2*ROOT_BITS-1:0]   radicand,
    output logic                     done,
    output logic [ROOT_BITS-1:0]     root
);

    localparam int CW = $clog2(ROOT_BITS + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CW-1:0]          cnt_reg;
    logic [2*ROOT_BITS-1:0] op_reg;
    logic [ROOT_BITS+1:0]   rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;

    logic [ROOT_BITS+3:0]   rem_trial;
    logic [ROOT_BITS+3:0]   trial;
    logic [ROOT_BITS+3:0]   diff;
    logic                   take;

    // One result bit per cycle: bring down two radicand bits and try 4*root+1.
    always_comb
    begin
        rem_trial = {rem_reg, op_reg[2*ROOT_BITS-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (rem_trial >= trial);
        diff      = rem_trial - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(ROOT_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath of the digit recurrence.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= op_reg << 2;
            rem_reg  <= take ? diff[ROOT_BITS+1:0] : rem_trial[ROOT_BITS+1:0];
            root_reg <= {root_reg[ROOT_BITS-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

`ifndef NO_ASSERTIONS
    // A finished root never coincides with a running recurrence.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("square root done while busy");

    // The remainder stays within 2*root+1.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({2'b00, rem_reg} <= {1'b0, root_reg, 1'b0} + 1'b1))
        else $error("square root remainder out of range");
`endif

endmodule

>>> tb/sv/ibs_checker.sv
module ibs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               opcode,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic [30:0]        in_radius,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    input  logic [30:0]        out_radius,
    output int                 fail_count,
    output int                 spheres_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint RAD_MAX = 64'h7FFF_FFFF;
    localparam longint POS_MAX = 64'sh7FFF_FFFF;
    localparam longint NEG_MIN = -64'sh8000_0000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] radius;
    } sphere_t;

    sphere_t expected_spheres[$];

    // Copy of the kept bounding sphere.
    longint kept_x, kept_y, kept_z;
    longint kept_radius;

    function automatic longint shift_axis(longint c, longint delta, longint g, longint d);
        logic [127:0] mag;
        logic [127:0] off;
        longint moved;
        mag = (delta < 0) ? 128'(-delta) : 128'(delta);
        off = (mag * 128'(g)) / (128'(d) * 2);
        moved = (delta < 0) ? c - longint'(off) : c + longint'(off);
        if (moved > POS_MAX) moved = POS_MAX;
        if (moved < NEG_MIN) moved = NEG_MIN;
        return moved;
    endfunction

    // Grow or restart the kept sphere with one incoming sphere.
    function automatic sphere_t grow_sphere(logic op, longint ix, longint iy, longint iz,
                                            longint ir);
        longint dx, dy, dz, d, m, g, nr;
        logic [127:0] mx, my, mz, sq, t;
        sphere_t s;
        if (op == ibs_pkg::OP_RESTART)
        begin
            kept_x = ix; kept_y = iy; kept_z = iz; kept_radius = ir;
        end
        else
        begin
            dx = ix - kept_x; dy = iy - kept_y; dz = iz - kept_z;
            mx = (dx < 0) ? 128'(-dx) : 128'(dx);
            my = (dy < 0) ? 128'(-dy) : 128'(dy);
            mz = (dz < 0) ? 128'(-dz) : 128'(dz);
            sq = mx * mx + my * my + mz * mz;
            d = 0;
            for (int b = 63; b >= 0; b--)
            begin
                t = 128'(d) | (128'(1) << b);
                if (t * t <= sq) d = longint'(t);
            end
            if (ir > kept_radius && d < ir - kept_radius)
            begin
                // The incoming sphere encloses the kept one.
                kept_x = ix; kept_y = iy; kept_z = iz; kept_radius = ir;
            end
            else if (d != 0)
            begin
                m = ir + d;
                if (m < kept_radius) m = kept_radius;
                g = m - kept_radius;
                nr = kept_radius + g / 2;
                kept_x = shift_axis(kept_x, dx, g, d);
                kept_y = shift_axis(kept_y, dy, g, d);
                kept_z = shift_axis(kept_z, dz, g, d);
                kept_radius = (nr > RAD_MAX) ? RAD_MAX : nr;
            end
        end
        s.x = kept_x[31:0];
        s.y = kept_y[31:0];
        s.z = kept_z[31:0];
        s.radius = kept_radius[30:0];
        return s;
    endfunction

    assign spheres_pending = expected_spheres.size();

    // Compare results first, then predict for the item taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        sphere_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            kept_x = 0; kept_y = 0; kept_z = 0; kept_radius = 0;
            expected_spheres.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_spheres.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: x=%h y=%h z=%h r=%h",
                                 out_x, out_y, out_z, out_radius);
                end
                else
                begin
                    want = expected_spheres.pop_front();
                    if (want.x !== out_x || want.y !== out_y || want.z !== out_z ||
                        want.radius !== out_radius)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("sphere mismatch: expected x=%h y=%h z=%h r=%h,",
                                     want.x, want.y, want.z, want.radius,
                                     " got x=%h y=%h z=%h r=%h",
                                     out_x, out_y, out_z, out_radius);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_spheres.push_back(grow_sphere(opcode, longint'(in_x),
                                                       longint'(in_y), longint'(in_z),
                                                       longint'(in_radius)));
        end
    end

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic signed [31:0] in_x, in_y, in_z;
    logic [30:0]        in_radius;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x, out_y, out_z;
    logic [30:0]        out_radius;
    int                 fail_count;
    int                 spheres_pending;
    logic               no_idle;
    logic               hold_request;
    int                 quiet_cycles;

    incremental_bounding_sphere_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_radius(in_radius),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_radius(out_radius)
    );

    ibs_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_radius(in_radius),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_radius(out_radius),
        .fail_count(fail_count), .spheres_pending(spheres_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random, or for one long stretch on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            out_ready = no_idle || ($urandom_range(99) >= 16);
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
            3:    return 32'($signed($urandom_range(400)) - 200);
            4:    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2 * 65536 * 4096)) - 65536 * 4096);
        endcase
    endfunction

    function automatic logic [30:0] pick_radius();
        case ($urandom_range(5))
            0:    return 31'($urandom);
            1:    return 31'd0;
            2:    return 31'($urandom_range(65536 * 64));
            3:    return 31'(31'h7FFF_FFFF - $urandom_range(3));
            default: return 31'($urandom_range(65536 * 4096));
        endcase
    endfunction

    // Offers one item and waits for it to be taken; may idle afterwards.
    task automatic send_item(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [30:0] r);
        opcode = op; in_x = x; in_y = y; in_z = z; in_radius = r;
        in_valid = 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 16)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    initial
    begin
        int seq_len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = ibs_pkg::OP_RESTART;
        in_x = '0; in_y = '0; in_z = '0; in_radius = '0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items: extremes and every special case of a merge.
        send_item(ibs_pkg::OP_MERGE, 32'h0001_0000, 32'h0, 32'h0, 31'h0);
        send_item(ibs_pkg::OP_RESTART, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
        send_item(ibs_pkg::OP_MERGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  31'h7FFF_FFFF);
        send_item(ibs_pkg::OP_MERGE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  31'h7FFF_FFFF);
        send_item(ibs_pkg::OP_RESTART, 32'h0, 32'h0, 32'h0, 31'h0001_0000);
        // Same center, smaller then equal radius: sphere unchanged.
        send_item(ibs_pkg::OP_MERGE, 32'h0, 32'h0, 32'h0, 31'h0000_8000);
        send_item(ibs_pkg::OP_MERGE, 32'h0, 32'h0, 32'h0, 31'h0001_0000);
        // Same center, larger radius: the incoming sphere encloses.
        send_item(ibs_pkg::OP_MERGE, 32'h0, 32'h0, 32'h0, 31'h0004_0000);
        // Off-center enclosing sphere.
        send_item(ibs_pkg::OP_MERGE, 32'h0000_8000, 32'hFFFF_0000, 32'h0, 31'h0010_0000);
        // Contained sphere, then a point on the boundary.
        send_item(ibs_pkg::OP_MERGE, 32'h0001_0000, 32'h0000_8000, 32'h0, 31'h0000_1000);
        send_item(ibs_pkg::OP_MERGE, 32'h0010_8000, 32'hFFFF_0000, 32'h0, 31'h0);
        // Points that grow the sphere.
        send_item(ibs_pkg::OP_MERGE, 32'hFF00_0000, 32'h0100_0000, 32'h0030_0000, 31'h0);
        send_item(ibs_pkg::OP_MERGE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003,
                  31'h0000_0005);
        // Radius saturation.
        send_item(ibs_pkg::OP_RESTART, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
        send_item(ibs_pkg::OP_MERGE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  31'h7FFF_FFFF);
        send_item(ibs_pkg::OP_RESTART, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                  31'h5555_5555);
        send_item(ibs_pkg::OP_MERGE, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA);

        // Random runs: usually a restart, followed by a run of items that are mostly merges.
        for (int n = 0; n < 1030; n += seq_len)
        begin
            seq_len = $urandom_range(1, 12);
            no_idle = (n >= 300 && n < 500);
            if (n >= 600 && n < 612)
                hold_request = 1'b1;
            if (n >= 800 && n < 812)
            begin
                in_valid = 1'b0;
                wait (spheres_pending == 0);
                @(negedge clk);
            end
            if ($urandom_range(9) != 0)
                send_item(ibs_pkg::OP_RESTART, pick_coord(), pick_coord(), pick_coord(),
                          pick_radius());
            for (int k = 1; k < seq_len; k++)
                send_item($urandom_range(7) != 0 ? ibs_pkg::OP_MERGE : ibs_pkg::OP_RESTART,
                          pick_coord(), pick_coord(), pick_coord(), pick_radius());
        end
        in_valid = 1'b0;

        wait (spheres_pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
